[hdl/skv_pkg.sv]
// skv_pkg: shared sizes, operation codes and status codes for the key/value table
// depends on nothing; used by small_key_value_table and tb_small_key_value_table
package skv_pkg;

    // table sizing
    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // port field widths
    localparam int OP_W     = 2;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // stored widths: only the low bits of the port words take part
    localparam int KEY_W   = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
    localparam int VAL_W   = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    // request operations
    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 2'd0,
        OP_APPEND = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CHANGE = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_MISS = 2'd3
    } status_t;

endpackage

[hdl/small_key_value_table.sv]
// small_key_value_table: fixed-capacity key/value table, one slot compared per cycle
// Steps: capture on transfer, scan of the slots (stops at the first matching key), update,
// then the result is held until taken.
// No request is taken until the last result is taken; one key comparator sets the pace.
// Reset: valid bits and the entry count clear at once; key and value stores are not cleared.
// depends on skv_pkg
module small_key_value_table
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [skv_pkg::OP_W-1:0]      op,
    input  logic [skv_pkg::FIELD_W-1:0]   key,
    input  logic [skv_pkg::FIELD_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [skv_pkg::FIELD_W-1:0]   value_out,
    output logic [skv_pkg::STATUS_W-1:0]  status,
    output logic [skv_pkg::OCC_W-1:0]     occupied
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } state_t;

    localparam logic [skv_pkg::IDX_W-1:0] LAST_IDX = skv_pkg::IDX_W'(skv_pkg::CAPACITY - 1);

    // slot storage
    logic [skv_pkg::CAPACITY-1:0] valid_reg, valid_next;
    logic [skv_pkg::KEY_W-1:0]    key_mem [skv_pkg::CAPACITY];
    logic [skv_pkg::VAL_W-1:0]    val_mem [skv_pkg::CAPACITY];
    logic [skv_pkg::COUNT_W-1:0]  count_reg, count_next;

    // registered read data of the slot under scan
    logic [skv_pkg::KEY_W-1:0]    key_rd_reg;
    logic [skv_pkg::VAL_W-1:0]    val_rd_reg;

    // sequencer and request registers
    state_t                     state_reg, state_next;
    logic [skv_pkg::IDX_W-1:0]  idx_reg, idx_next;
    skv_pkg::op_t               req_op_reg, req_op_next;
    logic [skv_pkg::KEY_W-1:0]  req_key_reg, req_key_next;
    logic [skv_pkg::VAL_W-1:0]  req_val_reg, req_val_next;
    logic                       hit_reg, hit_next;
    logic [skv_pkg::IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [skv_pkg::VAL_W-1:0]  hit_val_reg, hit_val_next;
    logic                       free_reg, free_next;
    logic [skv_pkg::IDX_W-1:0]  free_idx_reg, free_idx_next;

    // result registers
    logic                          out_valid_reg, out_valid_next;
    logic                          found_reg, found_next;
    logic [skv_pkg::FIELD_W-1:0]   value_out_reg, value_out_next;
    skv_pkg::status_t              status_reg, status_next;

    // store write port
    logic                       wr_key_en, wr_val_en;
    logic [skv_pkg::IDX_W-1:0]  wr_idx;

    // shared comparator on the slot under scan
    logic slot_valid, slot_hit;

    assign slot_valid = valid_reg[idx_reg];
    assign slot_hit   = slot_valid && (key_rd_reg == req_key_reg);

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        req_op_next    = req_op_reg;
        req_key_next   = req_key_reg;
        req_val_next   = req_val_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_val_next   = hit_val_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        value_out_next = value_out_reg;
        status_next    = status_reg;
        wr_key_en      = 1'b0;
        wr_val_en      = 1'b0;
        wr_idx         = hit_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // capture the request on transfer
                if (in_valid)
                begin
                    req_op_next  = skv_pkg::op_t'(op);
                    req_key_next = key[skv_pkg::KEY_W-1:0];
                    req_val_next = value[skv_pkg::VAL_W-1:0];
                    idx_next     = '0;
                    hit_next     = 1'b0;
                    free_next    = 1'b0;
                    state_next   = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // one slot per cycle, stop on the first key match
                if (slot_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                    hit_val_next = val_rd_reg;
                    state_next   = S_UPDATE;
                end
                else
                begin
                    // remember the lowest free slot
                    if (!slot_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        idx_next = idx_reg + skv_pkg::IDX_W'(1);
                    end
                end
            end

            S_UPDATE:
            begin
                found_next     = hit_reg;
                value_out_next = '0;
                status_next    = skv_pkg::ST_OK;
                unique case (req_op_reg)
                    skv_pkg::OP_FIND:
                    begin
                        if (hit_reg)
                        begin
                            value_out_next = skv_pkg::FIELD_W'(hit_val_reg);
                        end
                        else
                        begin
                            status_next = skv_pkg::ST_MISS;
                        end
                    end
                    skv_pkg::OP_APPEND:
                    begin
                        // duplicate check comes before the full check
                        if (hit_reg)
                        begin
                            status_next = skv_pkg::ST_DUP;
                        end
                        else if (free_reg)
                        begin
                            valid_next[free_idx_reg] = 1'b1;
                            count_next = count_reg + skv_pkg::COUNT_W'(1);
                            wr_key_en  = 1'b1;
                            wr_val_en  = 1'b1;
                            wr_idx     = free_idx_reg;
                        end
                        else
                        begin
                            status_next = skv_pkg::ST_FULL;
                        end
                    end
                    skv_pkg::OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            count_next = count_reg - skv_pkg::COUNT_W'(1);
                        end
                        else
                        begin
                            status_next = skv_pkg::ST_MISS;
                        end
                    end
                    skv_pkg::OP_CHANGE:
                    begin
                        if (hit_reg)
                        begin
                            wr_val_en = 1'b1;
                        end
                        else
                        begin
                            status_next = skv_pkg::ST_MISS;
                        end
                    end
                    default:
                    begin
                        status_next = skv_pkg::ST_MISS;
                    end
                endcase
                out_valid_next = 1'b1;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                // hold the result until the transfer
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            idx_reg       <= idx_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        req_op_reg    <= req_op_next;
        req_key_reg   <= req_key_next;
        req_val_reg   <= req_val_next;
        hit_idx_reg   <= hit_idx_next;
        hit_val_reg   <= hit_val_next;
        free_idx_reg  <= free_idx_next;
        found_reg     <= found_next;
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
    end

    // key and value stores, one write and one registered read per cycle
    // the read address runs one slot ahead so the data lines up with idx_reg
    always_ff @(posedge clk)
    begin
        if (wr_key_en)
        begin
            key_mem[wr_idx] <= req_key_reg;
        end
        if (wr_val_en)
        begin
            val_mem[wr_idx] <= req_val_reg;
        end
        key_rd_reg <= key_mem[idx_next];
        val_rd_reg <= val_mem[idx_next];
    end

    // port drive
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign occupied  = skv_pkg::OCC_W'(count_reg);

    // checks
    a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken while a result is pending");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == skv_pkg::COUNT_W'($countones(valid_reg)))
        else $error("entry count disagrees with valid bits");

    a_dup_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == skv_pkg::ST_DUP) |-> found)
        else $error("duplicate status without a key match");

    a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |=> out_valid)
        else $error("update cycle did not present a result");

endmodule

[sim/tb_small_key_value_table.sv]
// tb_small_key_value_table: self-checking bench for the key/value table, with a shadow copy
// of the slots, bursty request traffic and a stalling reply side
// depends on skv_pkg and small_key_value_table
module tb_small_key_value_table;

    import skv_pkg::*;

    typedef struct packed {
        op_t                op;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
        logic               wait_idle;
    } request_t;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] value_out;
        status_t            status;
        logic [OCC_W-1:0]   occupied;
    } reply_t;

    localparam int KEY_POOL = 20;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    op        = OP_FIND;
    logic [FIELD_W-1:0] key       = '0;
    logic [FIELD_W-1:0] value     = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               found;
    logic [FIELD_W-1:0] value_out;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]   occupied;

    // shadow of the table contents
    bit                 shadow_valid [CAPACITY];
    logic [KEY_W-1:0]   shadow_key   [CAPACITY];
    logic [VAL_W-1:0]   shadow_value [CAPACITY];
    int                 shadow_count = 0;

    request_t           request_queue [$];
    reply_t             reply_queue   [$];
    request_t           next_req;
    reply_t             want;
    int                 replies_owed  = 0;
    int                 replies_taken = 0;
    int                 error_count   = 0;

    // sender burst state and receiver stall state
    int                 burst_left = 0;
    int                 gap_left   = 0;
    int                 hold_left  = 0;
    bit                 long_hold_done = 1'b0;
    int                 ready_phase = 0;

    small_key_value_table u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .value_out (value_out),
        .status    (status),
        .occupied  (occupied)
    );

    // apply one request to the shadow table and return the reply it should give
    function automatic reply_t table_apply(input op_t req_op, input logic [FIELD_W-1:0] req_key,
                                           input logic [FIELD_W-1:0] req_value);
        reply_t           rep;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        int               hit;
        int               free_slot;
        k = req_key[KEY_W-1:0];
        v = req_value[VAL_W-1:0];
        hit = -1;
        free_slot = -1;
        // walk downwards so the lowest matching and lowest free slot win
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (shadow_valid[i] && shadow_key[i] == k)
                hit = i;
            if (!shadow_valid[i])
                free_slot = i;
        end
        rep.found = (hit >= 0);
        rep.value_out = '0;
        rep.status = ST_OK;
        case (req_op)
            OP_FIND:
            begin
                if (hit >= 0)
                    rep.value_out[VAL_W-1:0] = shadow_value[hit];
                else
                    rep.status = ST_MISS;
            end
            OP_APPEND:
            begin
                // duplicate takes precedence over full
                if (hit >= 0)
                    rep.status = ST_DUP;
                else if (free_slot < 0)
                    rep.status = ST_FULL;
                else
                begin
                    shadow_valid[free_slot] = 1'b1;
                    shadow_key[free_slot] = k;
                    shadow_value[free_slot] = v;
                    shadow_count++;
                end
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    shadow_valid[hit] = 1'b0;
                    shadow_count--;
                end
                else
                    rep.status = ST_MISS;
            end
            default:
            begin
                if (hit >= 0)
                    shadow_value[hit] = v;
                else
                    rep.status = ST_MISS;
            end
        endcase
        rep.occupied = shadow_count[OCC_W-1:0];
        return rep;
    endfunction

    task automatic queue_request(input op_t req_op, input logic [FIELD_W-1:0] req_key,
                                 input logic [FIELD_W-1:0] req_value, input logic idle_first);
        request_t r;
        r.op = req_op;
        r.key = req_key;
        r.value = req_value;
        r.wait_idle = idle_first;
        request_queue.push_back(r);
    endtask

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // request driver: bursts of transfers with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= OP_FIND;
            key <= '0;
            value <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                reply_queue.push_back(table_apply(op_t'(op), key, value));
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() != 0 &&
                         !(request_queue[0].wait_idle &&
                           (replies_owed + int'(in_valid && in_ready)
                            - int'(out_valid && out_ready)) != 0))
                begin
                    next_req = request_queue.pop_front();
                    in_valid <= 1'b1;
                    op <= next_req.op;
                    key <= next_req.key;
                    value <= next_req.value;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // reply side: rotating stall patterns plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            ready_phase <= 0;
        end
        else
        begin
            ready_phase <= ready_phase + 1;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && replies_taken >= 300)
            begin
                long_hold_done <= 1'b1;
                hold_left <= 400;
                out_ready <= 1'b0;
            end
            else
            begin
                case ((ready_phase / 97) % 4)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1);
                    2:       out_ready <= (ready_phase % 5 == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // reply checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            replies_owed <= replies_owed + int'(in_valid && in_ready)
                            - int'(out_valid && out_ready);
            if (out_valid && out_ready)
            begin
                replies_taken <= replies_taken + 1;
                if (reply_queue.size() == 0)
                begin
                    $error("reply transfer with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0h, got %0h", want.found, found);
                        error_count++;
                    end
                    if (value_out !== want.value_out)
                    begin
                        $error("value_out: expected %h, got %h", want.value_out, value_out);
                        error_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (occupied !== want.occupied)
                    begin
                        $error("occupied: expected %0d, got %0d", want.occupied, occupied);
                        error_count++;
                    end
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        logic [FIELD_W-1:0] key_pool [KEY_POOL];
        op_t                pick_op;
        logic [FIELD_W-1:0] pick_key;
        int                 roll;

        // directed: empty table misses
        queue_request(OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_request(OP_CHANGE, 32'h8000_0001, 32'h1234_5678, 1'b0);
        // extreme keys and values, duplicate, change then find
        queue_request(OP_APPEND, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_APPEND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_request(OP_APPEND, 32'h0000_0000, 32'h5555_5555, 1'b0);
        queue_request(OP_CHANGE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0);
        queue_request(OP_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        // fill the rest of the table
        for (int i = 0; i < CAPACITY - 2; i++)
            queue_request(OP_APPEND, $urandom(), $urandom(), 1'b0);
        // full table, duplicate on a full table, then a freed slot reused
        queue_request(OP_APPEND, 32'h7FFF_FFFE, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_APPEND, 32'h0000_0000, 32'h0000_0001, 1'b0);
        queue_request(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_FIND,   32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_request(OP_APPEND, 32'h0000_0000, 32'hC3C3_C3C3, 1'b0);

        // random: a small key pool so hits, fills and removals keep happening,
        // alternating between filling and draining phases
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom();
        for (int blk = 0; blk < 8; blk++)
        begin
            for (int n = 0; n < 200; n++)
            begin
                roll = $urandom_range(0, 99);
                if (blk % 2 == 0)
                    pick_op = (roll < 45) ? OP_APPEND : (roll < 70) ? OP_FIND :
                              (roll < 85) ? OP_CHANGE : OP_REMOVE;
                else
                    pick_op = (roll < 15) ? OP_APPEND : (roll < 45) ? OP_FIND :
                              (roll < 60) ? OP_CHANGE : OP_REMOVE;
                // stray keys only on lookups so the table does not silt up
                if (pick_op != OP_APPEND && $urandom_range(0, 9) == 0)
                    pick_key = $urandom();
                else
                    pick_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
                queue_request(pick_op, pick_key, $urandom(), (n == 0) && (blk % 2 == 0));
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last transfer and its reply
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || replies_owed != 0);
        repeat (CAPACITY + 8) @(posedge clk);
        if (reply_queue.size() != 0)
        begin
            $error("%0d replies never arrived", reply_queue.size());
            error_count++;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[small_key_value_table.f]
hdl/skv_pkg.sv
hdl/small_key_value_table.sv
sim/tb_small_key_value_table.sv
